### sv/egt_pkg.sv
// shared constants, tables and types of the ellipsoid grid tessellator
package egt_pkg;

  // field and register widths
  localparam int LAT_W      = 8;
  localparam int LON_W      = 9;
  localparam int CNT_W      = 9;
  localparam int RAD_W      = 16;
  localparam int MODE_W     = 2;
  localparam int VTX_W      = 17;
  localparam int SLOT_W     = 19;
  localparam int POS_W      = 17;
  localparam int TEX_W      = 16;
  localparam int NIDX_W     = 3;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;
  localparam int IN_DATA_W  = 24;
  localparam int OUT_DATA_W = 120;

  // grid limits
  localparam int MAX_LONGITUDES = 256;
  localparam int MAX_LATITUDES  = 256;
  localparam int MIN_GRID       = 3;

  // long division: one integer bit plus fraction bits, a few steps per stage
  localparam int DIV_FRAC_BITS = 33;
  localparam int DIV_STEPS     = 4;
  localparam int DIV_STAGES    = (DIV_FRAC_BITS + DIV_STEPS - 1) / DIV_STEPS;
  localparam int QUO_W         = DIV_FRAC_BITS + 1;
  localparam int TEX_SHIFT     = DIV_FRAC_BITS - TEX_W;

  // cordic in binary turns, 2^32 per turn, q2.30 data path
  localparam int CORDIC_STAGES_DEF = 16;
  localparam int CORDIC_MAX_STAGES = 24;
  localparam int TURN_W = 32;
  localparam int ANG_W  = 34;
  localparam int TRIG_W = 32;
  localparam int Q_FRAC = 30;
  localparam logic signed [ANG_W-1:0] CORDIC_GAIN  = 34'sh026DD3B6A;
  localparam logic signed [ANG_W-1:0] QUARTER_TURN = 34'sh040000000;
  localparam logic signed [ANG_W-1:0] HALF_TURN    = 34'sh080000000;

  localparam logic [TURN_W-1:0] ATAN_TURNS [CORDIC_MAX_STAGES] = '{
    32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4,
    32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
    32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
    32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D,
    32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
    32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051
  };

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_RADIUS_X = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_RADIUS_Y = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_RADIUS_Z = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_LONGS    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_LATS     = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_MODE     = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_TEX_EN   = 3'd6;

  // register reset values
  localparam logic [RAD_W-1:0]  RADIUS_RST = 16'd256;
  localparam logic [CNT_W-1:0]  LONGS_RST  = 9'd16;
  localparam logic [CNT_W-1:0]  LATS_RST   = 9'd8;
  localparam logic [MODE_W-1:0] MODE_RST   = 2'd2;

  // primitive modes
  localparam logic [MODE_W-1:0] PRIM_POINTS = 2'd0;
  localparam logic [MODE_W-1:0] PRIM_LINES  = 2'd1;
  localparam logic [MODE_W-1:0] PRIM_TRIS   = 2'd2;

  // index records per cell
  localparam logic [NIDX_W-1:0] NIDX_NONE   = 3'd0;
  localparam logic [NIDX_W-1:0] NIDX_POINTS = 3'd1;
  localparam logic [NIDX_W-1:0] NIDX_LINES  = 3'd4;
  localparam logic [NIDX_W-1:0] NIDX_TRIS   = 3'd6;

  typedef struct packed {
    logic [VTX_W-1:0]  vtx;
    logic [SLOT_W-1:0] cbase;
    logic [NIDX_W-1:0] nidx;
  } idx_info_t;

  typedef struct packed {
    logic [TEX_W-1:0] u;
    logic [TEX_W-1:0] v;
  } tex_t;

  typedef struct packed {
    idx_info_t               idx;
    logic signed [POS_W-1:0] px;
    logic signed [POS_W-1:0] py;
    logic signed [POS_W-1:0] pz;
    tex_t                    tex;
  } item_t;

endpackage

### sv/egt_div.sv
// pipelined restoring long division of a grid number by a grid count
module egt_div (
  input  logic                        clk,
  input  logic                        en,
  input  logic [egt_pkg::CNT_W-1:0]   num,
  input  logic [egt_pkg::CNT_W-1:0]   den,
  output logic [egt_pkg::QUO_W-1:0]   quo
);
  import egt_pkg::*;

  logic [CNT_W-1:0] rem_r [DIV_STAGES];
  logic [QUO_W-1:0] quo_r [DIV_STAGES];

  for (genvar s = 0; s < DIV_STAGES; s++) begin : g_stage
    logic [CNT_W-1:0] rem_in;
    logic [CNT_W-1:0] rem_nxt;
    logic [QUO_W-1:0] quo_in;
    logic [QUO_W-1:0] quo_nxt;

    // integer bit ahead of the first stage
    if (s == 0) begin : g_first
      logic int_ge;
      assign int_ge = (num >= den);
      assign rem_in = int_ge ? (num - den) : num;
      assign quo_in = QUO_W'(int_ge);
    end else begin : g_next
      assign rem_in = rem_r[s-1];
      assign quo_in = quo_r[s-1];
    end

    // one fraction bit per step
    always_comb begin
      logic [CNT_W:0] dbl;
      dbl     = '0;
      rem_nxt = rem_in;
      quo_nxt = quo_in;
      for (int k = 0; k < DIV_STEPS; k++) begin
        if (s * DIV_STEPS + k < DIV_FRAC_BITS) begin
          dbl = {rem_nxt, 1'b0};
          if (dbl >= {1'b0, den}) begin
            rem_nxt = CNT_W'(dbl - {1'b0, den});
            quo_nxt = {quo_nxt[QUO_W-2:0], 1'b1};
          end else begin
            rem_nxt = dbl[CNT_W-1:0];
            quo_nxt = {quo_nxt[QUO_W-2:0], 1'b0};
          end
        end
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[s] <= rem_nxt;
        quo_r[s] <= quo_nxt;
      end
    end
  end

  assign quo = quo_r[DIV_STAGES-1];

endmodule

### sv/egt_cordic.sv
// pipelined rotation cordic giving cosine and sine of an angle in turns
module egt_cordic #(
  parameter int STAGES = egt_pkg::CORDIC_STAGES_DEF
) (
  input  logic                              clk,
  input  logic                              en,
  input  logic [egt_pkg::TURN_W-1:0]        turn,
  output logic signed [egt_pkg::TRIG_W-1:0] cos_o,
  output logic signed [egt_pkg::TRIG_W-1:0] sin_o
);
  import egt_pkg::*;

  logic signed [ANG_W-1:0]  x_r [STAGES+1];
  logic signed [ANG_W-1:0]  y_r [STAGES+1];
  logic signed [ANG_W-1:0]  z_r [STAGES];
  logic                     neg_r [STAGES+1];
  logic signed [ANG_W-1:0]  ang;
  logic signed [ANG_W-1:0]  ang_fold;
  logic                     fold_neg;
  logic signed [TRIG_W-1:0] cos_r;
  logic signed [TRIG_W-1:0] sin_r;

  // fold into the right half plane, negate the result later
  always_comb begin
    ang      = ANG_W'(signed'(turn));
    ang_fold = ang;
    fold_neg = 1'b0;
    if (ang > QUARTER_TURN) begin
      ang_fold = ang - HALF_TURN;
      fold_neg = 1'b1;
    end else if (ang < -QUARTER_TURN) begin
      ang_fold = ang + HALF_TURN;
      fold_neg = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      x_r[0]   <= CORDIC_GAIN;
      y_r[0]   <= '0;
      z_r[0]   <= ang_fold;
      neg_r[0] <= fold_neg;
    end
  end

  // one micro-rotation per stage
  for (genvar i = 0; i < STAGES; i++) begin : g_iter
    always_ff @(posedge clk) begin
      if (en) begin
        neg_r[i+1] <= neg_r[i];
        if (z_r[i] >= 0) begin
          x_r[i+1] <= x_r[i] - (y_r[i] >>> i);
          y_r[i+1] <= y_r[i] + (x_r[i] >>> i);
        end else begin
          x_r[i+1] <= x_r[i] + (y_r[i] >>> i);
          y_r[i+1] <= y_r[i] - (x_r[i] >>> i);
        end
      end
    end
    if (i < STAGES - 1) begin : g_angle
      always_ff @(posedge clk) begin
        if (en) begin
          if (z_r[i] >= 0) begin
            z_r[i+1] <= z_r[i] - signed'(ANG_W'(ATAN_TURNS[i]));
          end else begin
            z_r[i+1] <= z_r[i] + signed'(ANG_W'(ATAN_TURNS[i]));
          end
        end
      end
    end
  end

  // undo the fold
  always_ff @(posedge clk) begin
    if (en) begin
      cos_r <= TRIG_W'(neg_r[STAGES] ? -x_r[STAGES] : x_r[STAGES]);
      sin_r <= TRIG_W'(neg_r[STAGES] ? -y_r[STAGES] : y_r[STAGES]);
    end
  end

  assign cos_o = cos_r;
  assign sin_o = sin_r;

endmodule

### sv/ellipsoid_grid_tessellator_top.sv
// path: input stage, dividers, angle registers, cordics, products, scaling, then the record register
// an input beat can be taken every cycle; the pipeline stalls only while its hold buffer is full
// result port: 1 + index count records per position (2 points, 5 lines, 7 triangles), sent by
// the single record register, one beat per cycle while out_tready is high
// reset: synchronous active low, clears all valid bits and restores register defaults
module ellipsoid_grid_tessellator_top #(
  parameter int CORDIC_STAGES = egt_pkg::CORDIC_STAGES_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_tvalid,
  output logic                              in_tready,
  input  logic [egt_pkg::IN_DATA_W-1:0]     in_tdata,   // lat_pos, lon_pos
  output logic                              out_tvalid,
  input  logic                              out_tready,
  output logic [egt_pkg::OUT_DATA_W-1:0]    out_tdata,  // slot, index_value, pos_x, pos_y,
                                                        // pos_z, tex_u, tex_v
  output logic                              out_tuser,  // record_kind
  output logic                              out_tlast,
  input  logic                              cfg_we,
  input  logic [egt_pkg::CFG_IDX_W-1:0]     cfg_addr,
  input  logic [egt_pkg::CFG_DATA_W-1:0]    cfg_wdata
);
  import egt_pkg::*;

  localparam int CORDIC_LAT = CORDIC_STAGES + 2;
  localparam int LAT        = DIV_STAGES + CORDIC_LAT + 6;
  localparam int IDX_DEPTH  = LAT - 2;
  localparam int TEX_DEPTH  = CORDIC_LAT + 5;
  localparam int PROD_W     = 2 * TRIG_W;
  localparam int POSP_W     = RAD_W + 1 + TRIG_W;
  localparam logic signed [PROD_W-1:0] PROD_HALF = PROD_W'(64'sh20000000);
  localparam logic signed [POSP_W-1:0] POSP_HALF = POSP_W'(64'sh20000000);
  localparam logic signed [POSP_W-1:0] POS_MAX   = POSP_W'(64'sd65535);

  // configuration registers
  logic [RAD_W-1:0]  rad_x_r, rad_y_r, rad_z_r;
  logic [CNT_W-1:0]  longs_r, lats_r;
  logic [MODE_W-1:0] mode_r;
  logic              tex_en_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rad_x_r  <= RADIUS_RST;
      rad_y_r  <= RADIUS_RST;
      rad_z_r  <= RADIUS_RST;
      longs_r  <= LONGS_RST;
      lats_r   <= LATS_RST;
      mode_r   <= MODE_RST;
      tex_en_r <= 1'b1;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        CFG_RADIUS_X: rad_x_r  <= cfg_wdata[RAD_W-1:0];
        CFG_RADIUS_Y: rad_y_r  <= cfg_wdata[RAD_W-1:0];
        CFG_RADIUS_Z: rad_z_r  <= cfg_wdata[RAD_W-1:0];
        CFG_LONGS:    longs_r  <= cfg_wdata[CNT_W-1:0];
        CFG_LATS:     lats_r   <= cfg_wdata[CNT_W-1:0];
        CFG_MODE:     mode_r   <= cfg_wdata[MODE_W-1:0];
        CFG_TEX_EN:   tex_en_r <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  // pipeline control
  logic             en;
  logic             buf_vld_r;
  logic             vld_r [LAT];
  logic [LAT_W-1:0] in_lat;
  logic [LON_W-1:0] in_lon;
  logic             grid_ok;
  logic             pos_ok;

  assign en        = !buf_vld_r;
  assign in_tready = en;
  assign in_lat    = in_tdata[LAT_W-1:0];
  assign in_lon    = in_tdata[LAT_W +: LON_W];

  // positions off the grid or grids out of range give no records
  assign grid_ok = (longs_r >= CNT_W'(MIN_GRID)) && (lats_r >= CNT_W'(MIN_GRID)) &&
                   (int'(longs_r) <= MAX_LONGITUDES) && (int'(lats_r) <= MAX_LATITUDES);
  assign pos_ok  = grid_ok && (CNT_W'(in_lat) < lats_r) && (in_lon <= longs_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < LAT; i++) vld_r[i] <= 1'b0;
    end else if (en) begin
      vld_r[0] <= in_tvalid && pos_ok;
      for (int i = 1; i < LAT; i++) vld_r[i] <= vld_r[i-1];
    end
  end

  // input stage
  logic [LAT_W-1:0] lat_r;
  logic [LON_W-1:0] lon_r;

  always_ff @(posedge clk) begin
    if (en) begin
      lat_r <= in_lat;
      lon_r <= in_lon;
    end
  end

  // vertex number, cell number and index count
  logic [VTX_W-1:0]  vtx1_r, cell1_r;
  logic [NIDX_W-1:0] nidx1_r;
  logic [NIDX_W-1:0] nidx_c;
  logic              has_next_ring;

  assign has_next_ring = (CNT_W'(lat_r) + CNT_W'(1)) < lats_r;

  always_comb begin
    nidx_c = NIDX_NONE;
    if (lon_r < longs_r) begin
      case (mode_r)
        PRIM_POINTS: nidx_c = NIDX_POINTS;
        PRIM_LINES:  nidx_c = has_next_ring ? NIDX_LINES : NIDX_NONE;
        PRIM_TRIS:   nidx_c = has_next_ring ? NIDX_TRIS : NIDX_NONE;
        default:     nidx_c = NIDX_NONE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      vtx1_r  <= VTX_W'(lat_r) * (VTX_W'(longs_r) + VTX_W'(1)) + VTX_W'(lon_r);
      cell1_r <= VTX_W'(lat_r) * VTX_W'(longs_r) + VTX_W'(lon_r);
      nidx1_r <= nidx_c;
    end
  end

  // first index slot of the cell, then a delay line to the end
  idx_info_t         idx_r [IDX_DEPTH];
  logic [SLOT_W-1:0] cell_ext;
  logic [SLOT_W-1:0] cbase_c;

  assign cell_ext = SLOT_W'(cell1_r);

  always_comb begin
    case (nidx1_r)
      NIDX_POINTS: cbase_c = cell_ext;
      NIDX_LINES:  cbase_c = cell_ext << 2;
      NIDX_TRIS:   cbase_c = (cell_ext << 2) + (cell_ext << 1);
      default:     cbase_c = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (en) begin
      idx_r[0] <= '{vtx: vtx1_r, cbase: cbase_c, nidx: nidx1_r};
      for (int i = 1; i < IDX_DEPTH; i++) idx_r[i] <= idx_r[i-1];
    end
  end

  // grid fractions lat/(lats-1) and lon/longs
  logic [QUO_W-1:0] quo_lat, quo_lon;

  egt_div u_div_lat (
    .clk (clk),
    .en  (en),
    .num (CNT_W'(lat_r)),
    .den (lats_r - CNT_W'(1)),
    .quo (quo_lat)
  );

  egt_div u_div_lon (
    .clk (clk),
    .en  (en),
    .num (lon_r),
    .den (longs_r),
    .quo (quo_lon)
  );

  // angles in turns and rounded texture coordinates
  logic [TURN_W-1:0]          phi_r, psi_r;
  tex_t                       tex_r [TEX_DEPTH];
  logic [QUO_W:0]             phi_sum;
  logic [QUO_W-1:0]           psi_half;
  logic [TURN_W:0]            psi_rnd;
  logic signed [ANG_W-1:0]    psi_ang;
  logic [QUO_W-TEX_SHIFT:0]   u_sum, v_sum;

  assign phi_sum  = {1'b0, quo_lon} + (QUO_W+1)'(1);
  assign psi_half = (quo_lat >> 1) + QUO_W'(1);
  assign psi_rnd  = psi_half[TURN_W+1:1];
  assign psi_ang  = QUARTER_TURN - signed'(ANG_W'(psi_rnd));
  assign u_sum    = {1'b0, quo_lon[QUO_W-1:TEX_SHIFT]} + (QUO_W-TEX_SHIFT+1)'(1);
  assign v_sum    = {1'b0, quo_lat[QUO_W-1:TEX_SHIFT]} + (QUO_W-TEX_SHIFT+1)'(1);

  always_ff @(posedge clk) begin
    if (en) begin
      phi_r    <= phi_sum[TURN_W:1];
      psi_r    <= psi_ang[TURN_W-1:0];
      tex_r[0] <= tex_en_r ? '{u: u_sum[TEX_W:1], v: v_sum[TEX_W:1]} : '0;
      for (int i = 1; i < TEX_DEPTH; i++) tex_r[i] <= tex_r[i-1];
    end
  end

  // trig of both angles
  logic signed [TRIG_W-1:0] cpsi, spsi, cphi, sphi;

  egt_cordic #(.STAGES(CORDIC_STAGES)) u_cordic_psi (
    .clk   (clk),
    .en    (en),
    .turn  (psi_r),
    .cos_o (cpsi),
    .sin_o (spsi)
  );

  egt_cordic #(.STAGES(CORDIC_STAGES)) u_cordic_phi (
    .clk   (clk),
    .en    (en),
    .turn  (phi_r),
    .cos_o (cphi),
    .sin_o (sphi)
  );

  // cos(phi)*cos(psi) and sin(phi)*cos(psi), then round to q2.30
  logic signed [PROD_W-1:0] cc_p_r, sc_p_r;
  logic signed [TRIG_W-1:0] spsi1_r, spsi2_r, cc_r, sc_r;

  always_ff @(posedge clk) begin
    if (en) begin
      cc_p_r  <= cphi * cpsi;
      sc_p_r  <= sphi * cpsi;
      spsi1_r <= spsi;
      cc_r    <= TRIG_W'((cc_p_r + PROD_HALF) >>> Q_FRAC);
      sc_r    <= TRIG_W'((sc_p_r + PROD_HALF) >>> Q_FRAC);
      spsi2_r <= spsi1_r;
    end
  end

  // scale by the radii, round to q8.8 and saturate
  logic signed [POSP_W-1:0] px_p_r, py_p_r, pz_p_r;
  logic signed [POS_W-1:0]  px_r, py_r, pz_r;

  function automatic logic signed [POS_W-1:0] pos_sat(input logic signed [POSP_W-1:0] p);
    logic signed [POSP_W-1:0] r;
    r = (p + POSP_HALF) >>> Q_FRAC;
    if (r > POS_MAX) begin
      r = POS_MAX;
    end else if (r < -POS_MAX) begin
      r = -POS_MAX;
    end
    return POS_W'(r);
  endfunction

  always_ff @(posedge clk) begin
    if (en) begin
      px_p_r <= signed'({1'b0, rad_x_r}) * cc_r;
      py_p_r <= signed'({1'b0, rad_y_r}) * spsi2_r;
      pz_p_r <= signed'({1'b0, rad_z_r}) * sc_r;
      px_r   <= pos_sat(px_p_r);
      py_r   <= pos_sat(py_p_r);
      pz_r   <= pos_sat(pz_p_r);
    end
  end

  // hold buffer and record emitter
  item_t             pipe_item;
  item_t             item_r, buf_r;
  logic              emit_vld_r;
  logic [NIDX_W-1:0] k_r;
  logic              emit_last, emit_take, emit_free, pipe_out_vld;

  assign pipe_item    = '{idx: idx_r[IDX_DEPTH-1], px: px_r, py: py_r, pz: pz_r,
                          tex: tex_r[TEX_DEPTH-1]};
  assign emit_last    = (k_r == item_r.idx.nidx);
  assign emit_take    = emit_vld_r && out_tready;
  assign emit_free    = !emit_vld_r || (emit_take && emit_last);
  assign pipe_out_vld = vld_r[LAT-1] && en;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      emit_vld_r <= 1'b0;
      buf_vld_r  <= 1'b0;
      k_r        <= '0;
    end else if (emit_free) begin
      emit_vld_r <= buf_vld_r || pipe_out_vld;
      buf_vld_r  <= 1'b0;
      k_r        <= '0;
    end else begin
      if (emit_take) k_r <= k_r + NIDX_W'(1);
      if (pipe_out_vld) buf_vld_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (emit_free) begin
      item_r <= buf_vld_r ? buf_r : pipe_item;
    end
    if (!emit_free && pipe_out_vld) begin
      buf_r <= pipe_item;
    end
  end

  // record fields for the current beat
  logic [VTX_W-1:0]  row, vtx, v_next, v_down, v_diag, idx_val;
  logic [SLOT_W-1:0] slot;
  logic              is_vtx;

  assign is_vtx = (k_r == '0);
  assign row    = VTX_W'(longs_r) + VTX_W'(1);
  assign vtx    = item_r.idx.vtx;
  assign v_next = vtx + VTX_W'(1);
  assign v_down = vtx + row;
  assign v_diag = v_down + VTX_W'(1);
  assign slot   = is_vtx ? SLOT_W'(vtx) : item_r.idx.cbase + SLOT_W'(k_r - NIDX_W'(1));

  always_comb begin
    idx_val = '0;
    case (item_r.idx.nidx)
      NIDX_POINTS: idx_val = is_vtx ? '0 : vtx;
      NIDX_LINES: begin
        case (k_r)
          3'd1, 3'd3: idx_val = vtx;
          3'd2:       idx_val = v_down;
          3'd4:       idx_val = v_next;
          default:    idx_val = '0;
        endcase
      end
      NIDX_TRIS: begin
        case (k_r)
          3'd1, 3'd4: idx_val = vtx;
          3'd2:       idx_val = v_next;
          3'd3, 3'd5: idx_val = v_diag;
          3'd6:       idx_val = v_down;
          default:    idx_val = '0;
        endcase
      end
      default: idx_val = '0;
    endcase
  end

  assign out_tvalid = emit_vld_r;
  assign out_tuser  = !is_vtx;
  assign out_tlast  = emit_last;
  assign out_tdata  = {1'b0,
                       is_vtx ? item_r.tex.v : TEX_W'(0),
                       is_vtx ? item_r.tex.u : TEX_W'(0),
                       is_vtx ? item_r.pz : POS_W'(0),
                       is_vtx ? item_r.py : POS_W'(0),
                       is_vtx ? item_r.px : POS_W'(0),
                       idx_val,
                       slot};

  // checks
  a_k_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    emit_vld_r |-> (k_r <= item_r.idx.nidx))
    else $error("record counter past the index count");

  a_buf_only_when_busy: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(buf_vld_r) |-> emit_vld_r)
    else $error("hold buffer filled while emitter idle");

  a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (emit_vld_r && !out_tready) |=> (emit_vld_r && $stable(k_r)))
    else $error("stalled record moved");

endmodule
